[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, types and helper functions for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH       = 16;
  localparam int PRIO_LEVELS = 5 - 1 + 1;
  localparam int PRIO_MIN    = 1;
  localparam int PRIO_MAX    = PRIO_MIN + PRIO_LEVELS - 1;

  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam int LVL_W     = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
  localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ADDR_W    = LVL_W + SLOT_W;
  localparam int RAM_WORDS = PRIO_LEVELS * (2 ** SLOT_W);

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    logic empty;
    logic full;
    cnt_t count;
    lvl_t pop_lvl;
  } ctrl_status_t;

  // Out-of-range priorities are clamped into the legal band before mapping.
  function automatic lvl_t prio_to_lvl(input logic [PRIO_W-1:0] p);
    lvl_t lvl;
    if (p <= PRIO_W'(PRIO_MIN)) begin
      lvl = '0;
    end else if (p >= PRIO_W'(PRIO_MAX)) begin
      lvl = lvl_t'(PRIO_LEVELS - 1);
    end else begin
      lvl = lvl_t'(p - PRIO_W'(PRIO_MIN));
    end
    return lvl;
  endfunction

  function automatic logic [PRIO_W-1:0] lvl_to_prio(input lvl_t lvl);
    return PRIO_W'(lvl) + PRIO_W'(PRIO_MIN);
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    slot_t r;
    if (s == SLOT_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

[rtl/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue: one ring buffer per priority level, held in a
// single value RAM addressed by {level, slot}.
// ----------------------------------------------------------------------------
// A push or a refused transaction has its result valid in the cycle after
// acceptance; a successful pop passes through S_READ for the RAM read first.
// One transaction at a time: in_ready is high only in S_IDLE, so a new
// request is taken only after the last result has been accepted.
// Reset clears all pointers and counts, so the queue starts empty; the RAM
// contents are not cleared.
module stable_priority_queue import spq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [PRIO_W-1:0]         priority_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic signed [VALUE_W-1:0] popped_value,
  output logic [PRIO_W-1:0]         popped_priority,
  output logic [FILL_W-1:0]         fill_level
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t              state;
  ctrl_status_t        stat;
  slot_t               wr_slot;
  slot_t               rd_slot;
  lvl_t                push_lvl;
  logic                accept;
  logic                is_push;
  logic                push_go;
  logic                pop_go;
  logic [VALUE_W-1:0]  rd_data;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_HOLD);
  assign accept    = in_valid && in_ready;
  assign is_push   = (op_t'(op) == OP_PUSH);
  assign push_lvl  = prio_to_lvl(priority_req);
  assign push_go   = accept && is_push && !stat.full;
  assign pop_go    = accept && !is_push && !stat.empty;

  spq_lvl_ctrl u_lvl_ctrl (
    .clk      (clk),
    .rst      (rst),
    .push     (push_go),
    .pop      (pop_go),
    .push_lvl (push_lvl),
    .wr_slot  (wr_slot),
    .rd_slot  (rd_slot),
    .stat     (stat)
  );

  spq_ram #(
    .DATA_W    (VALUE_W),
    .NUM_WORDS (RAM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (push_go),
    .waddr ({push_lvl, wr_slot}),
    .wdata (value),
    .re    (pop_go),
    .raddr ({stat.pop_lvl, rd_slot}),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= pop_go ? S_READ : S_HOLD;
          end
        end
        S_READ: begin
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result registers; on a pop, popped_value is filled in the cycle after acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value    <= '0;
      popped_priority <= '0;
      if (is_push) begin
        if (stat.full) begin
          status     <= ST_FULL;
          fill_level <= FILL_W'(stat.count);
        end else begin
          status     <= ST_DONE;
          fill_level <= FILL_W'(stat.count + CNT_W'(1));
        end
      end else if (stat.empty) begin
        status     <= ST_EMPTY;
        fill_level <= FILL_W'(stat.count);
      end else begin
        status          <= ST_DONE;
        popped_priority <= lvl_to_prio(stat.pop_lvl);
        fill_level      <= FILL_W'(stat.count - CNT_W'(1));
      end
    end else if (state == S_READ) begin
      popped_value <= rd_data;
    end
  end

endmodule

[rtl/spq_ram.sv]
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int DATA_W    = 32,
  parameter int NUM_WORDS = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                              wdata,
  input  logic                                           re,
  input  logic [((NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                              rdata
);

  logic [DATA_W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/spq_lvl_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_lvl_ctrl
// Head and tail pointers and fill counts for the per-priority ring buffers,
// plus selection of the highest non-empty priority level for a pop.
// ----------------------------------------------------------------------------
module spq_lvl_ctrl import spq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic         pop,
  input  lvl_t         push_lvl,
  output slot_t        wr_slot,
  output slot_t        rd_slot,
  output ctrl_status_t stat
);

  slot_t head    [PRIO_LEVELS];
  slot_t tail    [PRIO_LEVELS];
  cnt_t  lvl_cnt [PRIO_LEVELS];
  cnt_t  total;
  lvl_t  top_lvl;

  // The last non-empty level in ascending order is the highest priority.
  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < PRIO_LEVELS; i++) begin
      if (lvl_cnt[i] != '0) begin
        top_lvl = lvl_t'(i);
      end
    end
  end

  assign wr_slot      = tail[push_lvl];
  assign rd_slot      = head[top_lvl];
  assign stat.empty   = (total == '0);
  assign stat.full    = (total == CNT_W'(DEPTH));
  assign stat.count   = total;
  assign stat.pop_lvl = top_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRIO_LEVELS; i++) begin
        head[i]    <= '0;
        tail[i]    <= '0;
        lvl_cnt[i] <= '0;
      end
      total <= '0;
    end else if (push) begin
      tail[push_lvl]    <= slot_inc(tail[push_lvl]);
      lvl_cnt[push_lvl] <= lvl_cnt[push_lvl] + CNT_W'(1);
      total             <= total + CNT_W'(1);
    end else if (pop) begin
      head[top_lvl]    <= slot_inc(head[top_lvl]);
      lvl_cnt[top_lvl] <= lvl_cnt[top_lvl] - CNT_W'(1);
      total            <= total - CNT_W'(1);
    end
  end

endmodule

[tb/sv/spq_order_checker.sv]
// ----------------------------------------------------------------------------
// spq_order_checker
// Watches both channels of the stable priority queue, keeps its own ordered
// copy of the held entries, and compares every result with the expected one.
// ----------------------------------------------------------------------------
module spq_order_checker
  import spq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      op,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [PRIO_W-1:0]         priority_req,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [STATUS_W-1:0]       status,
  input  logic signed [VALUE_W-1:0] popped_value,
  input  logic [PRIO_W-1:0]         popped_priority,
  input  logic [FILL_W-1:0]         fill_level,
  output int                        fail_count,
  output int                        results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 200;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } held_entry_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
    logic [FILL_W-1:0]         fill;
  } queue_result_t;

  held_entry_t   held_entries[$];
  queue_result_t expected_results[$];
  int            mismatches = 0;
  int            results_seen = 0;

  assign fail_count = mismatches;

  task automatic report_error(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("ERROR %0t ns: result %0d: %s", $time, results_seen, msg);
    end
    mismatches++;
  endtask

  // Applies one request to the held entries and returns the result it gives.
  function automatic queue_result_t predict_queue_op(input op_t req_op,
                                                     input logic signed [VALUE_W-1:0] req_value,
                                                     input logic [PRIO_W-1:0] req_prio);
    queue_result_t res;
    held_entry_t   entry;
    int            pos;
    res.status = ST_DONE;
    res.value  = '0;
    res.prio   = '0;
    if (req_op == OP_PUSH) begin
      if (held_entries.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        entry.value = req_value;
        if (req_prio < PRIO_W'(PRIO_MIN)) begin
          entry.prio = PRIO_W'(PRIO_MIN);
        end else if (req_prio > PRIO_W'(PRIO_MAX)) begin
          entry.prio = PRIO_W'(PRIO_MAX);
        end else begin
          entry.prio = req_prio;
        end
        // The new entry goes behind everything of equal or higher priority.
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio >= entry.prio) begin
          pos++;
        end
        held_entries.insert(pos, entry);
      end
    end else if (held_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      entry = held_entries.pop_front();
      res.value = entry.value;
      res.prio  = entry.prio;
    end
    res.fill = FILL_W'(held_entries.size());
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    queue_result_t oldest;
    if (rst) begin
      held_entries.delete();
      expected_results.delete();
      results_pending <= 0;
    end else begin
      // A result never leaves on the edge its request enters, so compare first.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected transaction, status %0d fill %0d",
                                 status, fill_level));
        end else begin
          oldest = expected_results.pop_front();
          if (status !== oldest.status) begin
            report_error($sformatf("status %0d, expected %0d", status, oldest.status));
          end
          if (popped_value !== oldest.value) begin
            report_error($sformatf("popped_value %0d, expected %0d",
                                   popped_value, oldest.value));
          end
          if (popped_priority !== oldest.prio) begin
            report_error($sformatf("popped_priority %0d, expected %0d",
                                   popped_priority, oldest.prio));
          end
          if (fill_level !== oldest.fill) begin
            report_error($sformatf("fill_level %0d, expected %0d", fill_level, oldest.fill));
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_queue_op(op_t'(op), value, priority_req));
      end
      results_pending <= expected_results.size();
    end
  end

endmodule

[tb/sv/stable_priority_queue_test.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue_test
// Drives push and pop requests into the stable priority queue: a directed
// pass over the corner cases, then phases of fill, drain and mixed traffic
// with bursty input and a stalling output. Checking is done by the checker.
// ----------------------------------------------------------------------------
module stable_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;
  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY} ready_pattern_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      op;
  logic signed [VALUE_W-1:0] value;
  logic [PRIO_W-1:0]         priority_req;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] popped_value;
  logic [PRIO_W-1:0]         popped_priority;
  logic [FILL_W-1:0]         fill_level;
  int                        fail_count;
  int                        results_pending;

  traffic_mix_t   mix = MIX_EVEN;
  int             phase_left = 0;
  logic [PRIO_W-1:0] prio_lo = PRIO_W'(PRIO_MIN);
  logic [PRIO_W-1:0] prio_hi = PRIO_W'(PRIO_MAX);
  ready_pattern_t ready_mode = RDY_ALWAYS;
  int             mode_left = 0;
  int             idle_cycles = 0;

  always #6 clk = ~clk;

  stable_priority_queue DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .value(value), .priority_req(priority_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .popped_value(popped_value),
    .popped_priority(popped_priority), .fill_level(fill_level)
  );

  spq_order_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .value(value), .priority_req(priority_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .popped_value(popped_value),
    .popped_priority(popped_priority), .fill_level(fill_level),
    .fail_count(fail_count), .results_pending(results_pending)
  );

  function automatic logic signed [VALUE_W-1:0] corner_value(input int k);
    case (k)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Presents one request and returns on the edge that accepts it.
  task automatic send_request(input op_t req_op, input logic signed [VALUE_W-1:0] req_value,
                              input logic [PRIO_W-1:0] req_prio);
    in_valid     <= 1'b1;
    op           <= req_op;
    value        <= req_value;
    priority_req <= req_prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The count from the checker is registered, so wait for a clock edge before looking.
  task automatic wait_all_results();
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // Traffic comes in phases that push the queue toward full, toward empty,
  // or hold it level; some phases use only two adjacent priorities so that
  // long runs of equal priority show up.
  task automatic pick_random_request(output op_t req_op,
                                     output logic signed [VALUE_W-1:0] req_value,
                                     output logic [PRIO_W-1:0] req_prio);
    int push_pct;
    int pick;
    if (phase_left == 0) begin
      mix = traffic_mix_t'($urandom_range(0, 2));
      phase_left = $urandom_range(8, 40);
      if ($urandom_range(0, 2) == 0) begin
        prio_lo = PRIO_W'($urandom_range(PRIO_MIN, PRIO_MAX - 1));
        prio_hi = prio_lo + 1'b1;
      end else begin
        prio_lo = PRIO_W'(PRIO_MIN);
        prio_hi = PRIO_W'(PRIO_MAX);
      end
    end
    phase_left--;
    case (mix)
      MIX_FILL:  push_pct = 85;
      MIX_DRAIN: push_pct = 15;
      default:   push_pct = 50;
    endcase
    req_op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    pick = $urandom_range(0, 19);
    req_value = (pick < 4) ? corner_value(pick) : $urandom;
    if ($urandom_range(0, 19) == 0) begin
      pick = $urandom_range(0, 2);
      req_prio = (pick == 0) ? '0 : PRIO_W'(5 + pick);
    end else begin
      req_prio = PRIO_W'($urandom_range(prio_lo, prio_hi));
    end
  endtask

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_pattern_t'($urandom_range(0, 2));
      mode_left  <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      default:    out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    op_t                       req_op;
    logic signed [VALUE_W-1:0] req_value;
    logic [PRIO_W-1:0]         req_prio;
    int                        burst_left;
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_PUSH;
    value        = '0;
    priority_req = PRIO_W'(PRIO_MIN);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Pop while empty, fill to the brim with every priority code including
    // the clamped ones, get refused once, then take a few from the head.
    send_request(OP_POP, $urandom, PRIO_W'(PRIO_MAX));
    for (int i = 0; i < DEPTH; i++) begin
      send_request(OP_PUSH, (i < 4) ? corner_value(i) : $urandom, PRIO_W'(i % 8));
    end
    send_request(OP_PUSH, 32'sh7FFF_FFFF, PRIO_W'(PRIO_MAX));
    repeat (5) send_request(OP_POP, $urandom, PRIO_W'($urandom_range(0, 7)));
    in_valid <= 1'b0;
    wait_all_results();

    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick_random_request(req_op, req_value, req_prio);
      send_request(req_op, req_value, req_prio);
      burst_left--;
      if (n % 200 == 199) begin
        in_valid <= 1'b0;
        wait_all_results();
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && results_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
